[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AST_NOW(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
    else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/core/fbh_pkg.sv]
`default_nettype none
package fbh_pkg;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;
  localparam int NUM_W  = ROW_W + 10;
  localparam int LINE_W = NUM_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_FAULT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STEP   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] t1;
    logic [7:0] b1;
    logic [7:0] t2;
    logic [7:0] b2;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input int unsigned r, input int unsigned c);
    cell_addr = ADDR_W'(r * MAX_WIDTH + c);
  endfunction
endpackage
`default_nettype wire

[rtl/core/fbh_ram.sv]
`default_nettype none
module fbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/fbh_div.sv]
`default_nettype none
module fbh_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [fbh_pkg::NUM_W-1:0] num,
  input  wire logic [fbh_pkg::HDIM_W-1:0]       den,
  output logic                                  done,
  output logic signed [fbh_pkg::NUM_W-1:0]      quo
);
  import fbh_pkg::*;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HDIM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [HDIM_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = {rem_r, q_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[NUM_W-1];
      q_nxt    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = HDIM_W'(trial - {1'b0, den});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = HDIM_W'(trial);
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -signed'(q_r) : signed'(q_r);
endmodule
`default_nettype wire

[rtl/core/fbh_front.sv]
`default_nettype none
module fbh_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fbh_pkg::cmd_t in_cmd,
  input  wire logic          pop,
  output fbh_pkg::head_t     head
);
  import fbh_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_cmd.op != OP_NONE);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rp_r];
endmodule
`default_nettype wire

[rtl/core/fbh_back.sv]
`default_nettype none
module fbh_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [8:0]     cfg_data,
  input  wire fbh_pkg::head_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_cell_value
);
  import fbh_pkg::*;

  typedef enum logic [7:0] {
    S_INIT  = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RDW   = 8'b00000100,
    S_CLR   = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_DIV1  = 8'b00100000,
    S_DIV2  = 8'b01000000,
    S_SWEEP = 8'b10000000
  } state_t;
  // row drain shares S_MUL entry: handled by drain_r

  state_t            st_r, st_nxt;
  logic [8:0]        width_r, height_r;
  logic [7:0]        step_r;
  logic [WDIM_W-1:0] eff_w;
  logic [HDIM_W-1:0] eff_h;
  cmd_t              cur_r, cur_nxt;
  logic [ADDR_W-1:0] init_r, init_nxt;
  logic [COL_W-1:0]  col_r, col_nxt, rcol_r, rcol_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              rv_r, rv_nxt, drain_r, drain_nxt;
  logic              oob_r, oob_nxt, run_r, run_nxt;
  logic signed [NUM_W-1:0]  n1_r, n1_nxt, n2_r, n2_nxt, dnum, quo;
  logic signed [LINE_W-1:0] l1_r, l1_nxt, l2_r, l2_nxt, xs;
  logic              dstart, ddone;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_d_r, out_d_nxt;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic [8:0]        sum;
  logic              out_free;

  assign eff_w = (int'(width_r) > MAX_WIDTH) ? WDIM_W'(MAX_WIDTH) : WDIM_W'(width_r);
  assign eff_h = (int'(height_r) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(height_r);
  assign out_free = !out_v_r || !out_stall;
  assign dnum = (st_r == S_DIV1) ? n1_r : n2_r;
  assign xs   = signed'(LINE_W'({1'b0, rcol_r}));
  assign sum  = {1'b0, rd_data} + {1'b0, step_r};

  fbh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dstart),
    .num  (dnum),
    .den  (eff_h),
    .done (ddone),
    .quo  (quo)
  );

  fbh_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    init_nxt  = init_r;
    col_nxt   = col_r;
    rcol_nxt  = rcol_r;
    row_nxt   = row_r;
    rv_nxt    = 1'b0;
    drain_nxt = 1'b0;
    oob_nxt   = oob_r;
    run_nxt   = run_r;
    n1_nxt    = n1_r;
    n2_nxt    = n2_r;
    l1_nxt    = l1_r;
    l2_nxt    = l2_r;
    dstart    = 1'b0;
    out_v_nxt = out_v_r && out_stall;
    out_d_nxt = out_d_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cell_addr(int'(row_r), int'(col_r));
    wr_en     = 1'b0;
    wr_addr   = cell_addr(int'(row_r), int'(rcol_r));
    wr_data   = 8'd128;

    if (rv_r) begin
      wr_en = 1'b1;
      if (xs <= l1_r && xs >= l2_r) begin
        wr_data = (sum > 9'd255) ? 8'd255 : sum[7:0];
      end else begin
        wr_data = (rd_data < step_r) ? 8'd0 : rd_data - step_r;
      end
    end

    case (st_r)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = init_r;
        init_nxt = init_r + 1'b1;
        if (int'(init_r) == DEPTH - 1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          cur_nxt = head.cmd;
          row_nxt = '0;
          col_nxt = '0;
          case (head.cmd.op)
            OP_READ: begin
              if (out_free) begin
                pop     = 1'b1;
                rd_en   = 1'b1;
                rd_addr = cell_addr(int'(head.cmd.row), int'(head.cmd.col));
                oob_nxt = !(int'(head.cmd.col) < MAX_WIDTH && int'(head.cmd.row) < MAX_HEIGHT);
                st_nxt  = S_RDW;
              end
            end
            OP_CLEAR: begin
              pop = 1'b1;
              if (eff_w != '0 && eff_h != '0) begin
                st_nxt = S_CLR;
              end
            end
            OP_FAULT: begin
              pop = 1'b1;
              if (eff_w != '0 && eff_h != '0) begin
                st_nxt = S_MUL;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      S_RDW: begin
        out_v_nxt = 1'b1;
        out_d_nxt = oob_r ? 8'd0 : rd_data;
        st_nxt    = S_IDLE;
      end
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(int'(row_r), int'(col_r));
        wr_data = 8'd128;
        if ({1'b0, col_r} == eff_w - 1'b1) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
          if ({1'b0, row_r} == eff_h - 1'b1) begin
            st_nxt = S_IDLE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_MUL: begin
        if (drain_r) begin
          if ({1'b0, row_r} == eff_h - 1'b1) begin
            st_nxt = S_IDLE;
          end else begin
            row_nxt   = row_r + 1'b1;
            drain_nxt = 1'b0;
          end
        end else begin
          n1_nxt = NUM_W'(signed'({1'b0, cur_r.t1}) - signed'({1'b0, cur_r.b1}))
                   * NUM_W'(signed'({1'b0, row_r}));
          n2_nxt = NUM_W'(signed'({1'b0, cur_r.t2}) - signed'({1'b0, cur_r.b2}))
                   * NUM_W'(signed'({1'b0, row_r}));
          st_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!run_r) begin
          dstart  = 1'b1;
          run_nxt = 1'b1;
        end else if (ddone) begin
          run_nxt = 1'b0;
          l1_nxt  = LINE_W'(quo) + signed'(LINE_W'({1'b0, cur_r.b1}));
          st_nxt  = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!run_r) begin
          dstart  = 1'b1;
          run_nxt = 1'b1;
        end else if (ddone) begin
          run_nxt = 1'b0;
          l2_nxt  = LINE_W'(quo) + signed'(LINE_W'({1'b0, cur_r.b2}));
          col_nxt = '0;
          st_nxt  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        rd_en    = 1'b1;
        rv_nxt   = 1'b1;
        rcol_nxt = col_r;
        if ({1'b0, col_r} == eff_w - 1'b1) begin
          drain_nxt = 1'b1;
          st_nxt    = S_MUL;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_INIT;
      init_r   <= '0;
      rv_r     <= 1'b0;
      drain_r  <= 1'b0;
      run_r    <= 1'b0;
      out_v_r  <= 1'b0;
      width_r  <= 9'd256;
      height_r <= 9'd256;
      step_r   <= 8'd1;
    end else begin
      st_r    <= st_nxt;
      init_r  <= init_nxt;
      rv_r    <= rv_nxt;
      drain_r <= drain_nxt;
      run_r   <= run_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WIDTH:  width_r  <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          REG_STEP:   step_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    cur_r   <= cur_nxt;
    col_r   <= col_nxt;
    rcol_r  <= rcol_nxt;
    row_r   <= row_nxt;
    oob_r   <= oob_nxt;
    n1_r    <= n1_nxt;
    n2_r    <= n2_nxt;
    l1_r    <= l1_nxt;
    l2_r    <= l2_nxt;
    out_d_r <= out_d_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_cell_value = out_d_r;
endmodule
`default_nettype wire

[rtl/core/fault_band_heightmap.sv]
// Fault-band heightmap engine, 256 x 256 cells of 8 bits.
// Input channel (in_valid/in_stall): one item per command: clear, fault
// or read. Code 3 is taken and dropped. Items enter a two-deep queue,
// so in_stall rises only when two commands wait in the queue.
// Output channel (out_valid/out_stall): one cell_value item per read,
// held in an output register until taken.
// Config port (cfg_we/cfg_index/cfg_data): width, height, step; write
// only while no command is in work.
// Steps per command, in a cell memory with one read and one write port:
//   read  S_IDLE issues the memory read, S_RDW loads the output register
//   clear S_CLR writes 128 into each of the W*H cells in turn
//   fault per row S_MUL, S_DIV1, S_DIV2, then S_SWEEP over W columns;
//         the two per-row line divisions run on one serial divider.
// After reset the back end writes 128 into all 65536 cells, one a cycle,
// and starts no command before the last; items still fill the queue.
// A stalled output holds its item; a following read waits for it.
`default_nettype none
`include "assert_macros.svh"
module fault_band_heightmap (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_top_x_first,
  input  wire logic [7:0] in_bottom_x_first,
  input  wire logic [7:0] in_top_x_second,
  input  wire logic [7:0] in_bottom_x_second,
  input  wire logic [7:0] in_read_column,
  input  wire logic [7:0] in_read_row,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_cell_value,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  import fbh_pkg::*;

  cmd_t  in_cmd;
  head_t head;
  logic  pop;

  assign in_cmd.op  = op_t'(in_operation);
  assign in_cmd.t1  = in_top_x_first;
  assign in_cmd.b1  = in_bottom_x_first;
  assign in_cmd.t2  = in_top_x_second;
  assign in_cmd.b2  = in_bottom_x_second;
  assign in_cmd.col = in_read_column;
  assign in_cmd.row = in_read_row;

  fbh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd  (in_cmd),
    .pop     (pop),
    .head    (head)
  );

  fbh_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_value(out_cell_value)
  );

  `AST_NOW(a_pop_has_head, clk, rst_n, pop, head.valid)
  `AST_NEXT(a_read_pop_frees_out, clk, rst_n, pop && head.cmd.op == OP_READ, !out_valid)
endmodule
`default_nettype wire
